// ----- sv/c128_pkg.sv -----
`timescale 1ns / 1ps
// c128_pkg: types, constants and the symbol pattern table of the Code 128-B encoder.
// No dependencies; the top level, front, queue and back files import it.
package c128_pkg;

   localparam logic [7:0]  CHAR_LOW     = 8'd32;
   localparam logic [7:0]  CHAR_HIGH    = 8'd126;
   localparam logic [6:0]  SYM_START_B  = 7'd104;
   localparam logic [6:0]  SYM_STOP     = 7'd106;
   localparam logic [6:0]  CHECK_MOD    = 7'd103;
   // start value reduced modulo 103
   localparam logic [6:0]  START_CHECK  = 7'd1;
   localparam logic [3:0]  BASE_LENGTH  = 4'd11;
   localparam logic [3:0]  STOP_LENGTH  = 4'd13;
   localparam logic [12:0] STOP_PATTERN = 13'b1100011101011;
   // ceil(2^20 / 103), exact quotient for all products below 15650
   localparam logic [13:0] RECIP_103    = 14'd10181;
   localparam int          RECIP_SHIFT  = 20;

   // One classified character travelling from front to back.
   typedef struct packed {
      logic       err;     // character out of range, abort message
      logic       start;   // first character, emit start-B first
      logic       last;    // last character, emit check and stop after
      logic [6:0] val;     // symbol value of the character
      logic [6:0] rem;     // (val * position) mod 103
   } c128_job_type;

   localparam logic [10:0] PATTERNS [0:105] = '{
      11'b11011001100, 11'b11001101100, 11'b11001100110, 11'b10010011000,
      11'b10010001100, 11'b10001001100, 11'b10011001000, 11'b10011000100,
      11'b10001100100, 11'b11001001000, 11'b11001000100, 11'b11000100100,
      11'b10110011100, 11'b10011011100, 11'b10011001110, 11'b10111001100,
      11'b10011101100, 11'b10011100110, 11'b11001110010, 11'b11001011100,
      11'b11001001110, 11'b11011100100, 11'b11001110100, 11'b11101101110,
      11'b11101001100, 11'b11100101100, 11'b11100100110, 11'b11101100100,
      11'b11100110100, 11'b11100110010, 11'b11011011000, 11'b11011000110,
      11'b11000110110, 11'b10100011000, 11'b10001011000, 11'b10001000110,
      11'b10110001000, 11'b10001101000, 11'b10001100010, 11'b11010001000,
      11'b11000101000, 11'b11000100010, 11'b10110111000, 11'b10110001110,
      11'b10001101110, 11'b10111011000, 11'b10111000110, 11'b10001110110,
      11'b11101110110, 11'b11010001110, 11'b11000101110, 11'b11011101000,
      11'b11011100010, 11'b11011101110, 11'b11101011000, 11'b11101000110,
      11'b11100010110, 11'b11101101000, 11'b11101100010, 11'b11100011010,
      11'b11101111010, 11'b11001000010, 11'b11110001010, 11'b10100110000,
      11'b10100001100, 11'b10010110000, 11'b10010000110, 11'b10000101100,
      11'b10000100110, 11'b10110010000, 11'b10110000100, 11'b10011010000,
      11'b10011000010, 11'b10000110100, 11'b10000110010, 11'b11000010010,
      11'b11001010000, 11'b11110111010, 11'b11000010100, 11'b10001111010,
      11'b10100111100, 11'b10010111100, 11'b10010011110, 11'b10111100100,
      11'b10011110100, 11'b10011110010, 11'b11110100100, 11'b11110010100,
      11'b11110010010, 11'b11011011110, 11'b11011110110, 11'b11110110110,
      11'b10101111000, 11'b10100011110, 11'b10001011110, 11'b10111101000,
      11'b10111100010, 11'b11110101000, 11'b11110100010, 11'b10111011110,
      11'b10111101110, 11'b11101011110, 11'b11110101110, 11'b11010000100,
      11'b11010010000, 11'b11010011100
   };

   function automatic logic [12:0] c128_pattern(input logic [6:0] sym);
      logic [12:0] pat;
      pat = '0;
      if (sym == SYM_STOP) begin
         pat = STOP_PATTERN;
      end else if (sym < SYM_STOP) begin
         pat = {2'b00, PATTERNS[sym]};
      end
      return pat;
   endfunction

endpackage

// ----- sv/c128_req_if.sv -----
`timescale 1ns / 1ps
// c128_req_if: character channel (valid/ready plus character payload).
// Standalone; used by the encoder front end.
interface c128_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       message_end;

   modport source (output valid, output char_code, output message_end, input ready);
   modport sink   (input valid, input char_code, input message_end, output ready);
endinterface

// ----- sv/c128_rsp_if.sv -----
`timescale 1ns / 1ps
// c128_rsp_if: symbol channel (valid/ready plus symbol payload).
// Standalone; used by the encoder back end.
interface c128_rsp_if;
   logic        valid;
   logic        ready;
   logic [12:0] bar_pattern;
   logic [3:0]  pattern_length;
   logic [6:0]  symbol_value;
   logic        char_error;
   logic        run_last;

   modport source (output valid, output bar_pattern, output pattern_length,
                   output symbol_value, output char_error, output run_last,
                   input ready);
   modport sink   (input valid, input bar_pattern, input pattern_length,
                   input symbol_value, input char_error, input run_last,
                   output ready);
endinterface

// ----- sv/code128b_symbol_encoder_unit.sv -----
`timescale 1ns / 1ps
// code128b_symbol_encoder_unit: top level of the Code 128 subset B encoder.
// Depends on c128_pkg, c128_req_if, c128_rsp_if, c128_front, c128_queue, c128_back.
//
// Takes one ASCII character per transaction on req_bus (message_end marks the
// last character) and returns Code 128 symbols on rsp_bus, one per transaction.
// A message opens with start-B (104); each character 32..126 gives the symbol
// value char-32; the last character is followed by the mod-103 check symbol and
// the 13-module stop symbol (106). A character outside 32..126 gives a single
// result with char_error set and zero pattern, and aborts the message.
// Throughput: one character per cycle on req_bus while the queue has room; rsp_bus
// delivers one symbol per cycle while the receiver is ready, so a message of N
// characters yields N+3 symbols, the extra three being start, check and stop. The
// output port is the bottleneck at message boundaries; the queue absorbs those
// bursts. A character passes the first front stage (classify and multiply by
// position), loaded at acceptance, then the second front stage (reciprocal
// quotient for mod 103), the queue, the back end's job register and its output
// register before its first result is valid. req_bus is not ready while reset is
// held. No clearing pass is needed after reset.

module code128b_symbol_encoder_unit import c128_pkg::*; #(
   parameter int QUEUE_DEPTH = 4   // entries between front and back, at least 2
) (
   input  logic       clock,
   input  logic       reset,
   c128_req_if.sink   req_bus,
   c128_rsp_if.source rsp_bus
);

   // front to queue
   logic         push;
   c128_job_type push_job;
   logic         full;

   // queue to back
   c128_job_type head;
   logic         empty;
   logic         pop;

   // Front: handshake, message state, position weight and checksum term.
   c128_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .push    (push),
      .job     (push_job),
      .full    (full)
   );

   // Decoupling queue so that character intake keeps going while the back end
   // spends extra cycles on start/check/stop symbols.
   c128_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (head),
      .empty    (empty),
      .full     (full)
   );

   // Back: running checksum, symbol sequencing and registered output.
   c128_back u_back (
      .clock   (clock),
      .reset   (reset),
      .head    (head),
      .empty   (empty),
      .pop     (pop),
      .rsp_bus (rsp_bus)
   );

endmodule

// ----- sv/c128_front.sv -----
`timescale 1ns / 1ps
// c128_front: accepts characters, classifies them and forms the checksum term.
// Depends on c128_pkg and c128_req_if.
module c128_front import c128_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   c128_req_if.sink     req_bus,
   output logic         push,
   output c128_job_type job,
   input  logic         full
);

   logic        in_message_ff, in_message_in;
   logic [6:0]  weight_ff, weight_in;
   logic        accept;
   logic        char_bad;
   logic [6:0]  char_val;
   logic [6:0]  eff_weight;

   // stage 1: classification and product
   logic        s1_valid_ff;
   logic        s1_err_ff, s1_start_ff, s1_last_ff;
   logic [6:0]  s1_val_ff;
   logic [13:0] s1_prod_ff;
   // stage 2: quotient estimate
   logic        s2_valid_ff;
   logic        s2_err_ff, s2_start_ff, s2_last_ff;
   logic [6:0]  s2_val_ff;
   logic [13:0] s2_prod_ff;
   logic [6:0]  s2_quot_ff;

   logic        s1_en, s2_en;
   logic [27:0] recip_prod;
   logic [13:0] rem_wide;

   assign s2_en         = !s2_valid_ff || !full;
   assign s1_en         = !s1_valid_ff || s2_en;
   // no transaction is taken while reset is held
   assign req_bus.ready = s1_en && !reset;
   assign accept        = req_bus.valid && s1_en && !reset;

   assign char_bad   = (req_bus.char_code < CHAR_LOW) || (req_bus.char_code > CHAR_HIGH);
   assign char_val   = 7'(req_bus.char_code - CHAR_LOW);
   assign eff_weight = in_message_ff ? weight_ff : 7'd1;

   always_comb begin
      in_message_in = in_message_ff;
      weight_in     = weight_ff;
      if (accept) begin
         if (char_bad || req_bus.message_end) begin
            in_message_in = 1'b0;
            weight_in     = '0;
         end else begin
            in_message_in = 1'b1;
            weight_in     = (eff_weight == CHECK_MOD - 7'd1) ? 7'd0 : eff_weight + 7'd1;
         end
      end
   end

   assign recip_prod = 28'(s1_prod_ff) * 28'(RECIP_103);
   assign rem_wide   = s2_prod_ff - 14'(s2_quot_ff) * 14'(CHECK_MOD);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_message_ff <= 1'b0;
         weight_ff     <= '0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
      end else begin
         in_message_ff <= in_message_in;
         weight_ff     <= weight_in;
         if (s1_en) begin
            s1_valid_ff <= accept;
         end
         if (s2_en) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
      if (accept) begin
         s1_err_ff   <= char_bad;
         s1_start_ff <= !in_message_ff;
         s1_last_ff  <= req_bus.message_end;
         s1_val_ff   <= char_val;
         s1_prod_ff  <= char_bad ? 14'd0 : 14'(char_val) * 14'(eff_weight);
      end
      if (s2_en && s1_valid_ff) begin
         s2_err_ff   <= s1_err_ff;
         s2_start_ff <= s1_start_ff;
         s2_last_ff  <= s1_last_ff;
         s2_val_ff   <= s1_val_ff;
         s2_prod_ff  <= s1_prod_ff;
         s2_quot_ff  <= recip_prod[RECIP_SHIFT +: 7];
      end
   end

   assign push      = s2_valid_ff && !full;
   assign job.err   = s2_err_ff;
   assign job.start = s2_start_ff;
   assign job.last  = s2_last_ff;
   assign job.val   = s2_val_ff;
   assign job.rem   = rem_wide[6:0];

endmodule

// ----- sv/c128_queue.sv -----
`timescale 1ns / 1ps
// c128_queue: small FIFO of classified characters between front and back.
// Depends on c128_pkg.
module c128_queue import c128_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  c128_job_type push_job,
   input  logic         pop,
   output c128_job_type head,
   output logic         empty,
   output logic         full
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   c128_job_type           slots_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]       count_ff;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == CNT_W'(DEPTH));
   assign head  = slots_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count exceeds depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full && !pop |-> !push)
      else $error("push into full queue");

endmodule

// ----- sv/c128_back.sv -----
`timescale 1ns / 1ps
// c128_back: expands each queued character into start/char/check/stop symbols, or one error symbol.
// Holds the running checksum; depends on c128_pkg and c128_rsp_if.
module c128_back import c128_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  c128_job_type head,
   input  logic         empty,
   output logic         pop,
   c128_rsp_if.source   rsp_bus
);

   typedef enum logic [2:0] {
      PH_START, PH_CHAR, PH_CHECK, PH_STOP, PH_ERROR
   } phase_type;

   phase_type    phase_ff, phase_in, load_phase;
   logic         job_valid_ff, job_valid_in;
   c128_job_type job_ff;
   logic [6:0]   chk_ff, chk_in;
   logic [7:0]   chk_sum;
   logic [6:0]   chk_base;

   logic         rsp_valid_ff, rsp_valid_in;
   logic [12:0]  bar_pattern_ff, bar_pattern_in;
   logic [3:0]   pattern_length_ff, pattern_length_in;
   logic [6:0]   symbol_value_ff, symbol_value_in;
   logic         char_error_ff, char_error_in;
   logic         run_last_ff, run_last_in;

   logic         advance;
   logic         last_phase;
   logic [6:0]   sym;

   assign advance    = !rsp_valid_ff || rsp_bus.ready;
   assign last_phase = (phase_ff == PH_ERROR) || (phase_ff == PH_STOP) ||
                       (phase_ff == PH_CHAR && !job_ff.last);
   assign pop        = !empty && (!job_valid_ff || (advance && last_phase));

   // checksum folds in the new term as the character is taken from the queue
   assign chk_base = head.start ? START_CHECK : chk_ff;
   assign chk_sum  = {1'b0, chk_base} + {1'b0, head.rem};

   always_comb begin
      if (head.err) begin
         load_phase = PH_ERROR;
      end else if (head.start) begin
         load_phase = PH_START;
      end else begin
         load_phase = PH_CHAR;
      end
   end

   always_comb begin
      case (phase_ff)
         PH_START: sym = SYM_START_B;
         PH_CHAR:  sym = job_ff.val;
         PH_CHECK: sym = chk_ff;
         PH_STOP:  sym = SYM_STOP;
         default:  sym = '0;
      endcase
   end

   always_comb begin
      phase_in          = phase_ff;
      job_valid_in      = job_valid_ff;
      chk_in            = chk_ff;
      rsp_valid_in      = rsp_valid_ff;
      bar_pattern_in    = bar_pattern_ff;
      pattern_length_in = pattern_length_ff;
      symbol_value_in   = symbol_value_ff;
      char_error_in     = char_error_ff;
      run_last_in       = run_last_ff;

      if (advance) begin
         rsp_valid_in = job_valid_ff;
         if (job_valid_ff) begin
            char_error_in     = (phase_ff == PH_ERROR);
            bar_pattern_in    = (phase_ff == PH_ERROR) ? 13'd0 : c128_pattern(sym);
            pattern_length_in = (phase_ff == PH_STOP) ? STOP_LENGTH : BASE_LENGTH;
            symbol_value_in   = sym;
            run_last_in       = last_phase;
            case (phase_ff)
               PH_START: phase_in = PH_CHAR;
               PH_CHAR:  phase_in = PH_CHECK;
               PH_CHECK: phase_in = PH_STOP;
               default:  phase_in = phase_ff;
            endcase
            if (last_phase) begin
               job_valid_in = 1'b0;
            end
         end
      end

      if (pop) begin
         job_valid_in = 1'b1;
         phase_in     = load_phase;
         if (!head.err) begin
            chk_in = (chk_sum >= 8'(CHECK_MOD)) ? 7'(chk_sum - 8'(CHECK_MOD)) : chk_sum[6:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_START;
         job_valid_ff <= 1'b0;
         chk_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         job_valid_ff <= job_valid_in;
         chk_ff       <= chk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (pop) begin
         job_ff <= head;
      end
      bar_pattern_ff    <= bar_pattern_in;
      pattern_length_ff <= pattern_length_in;
      symbol_value_ff   <= symbol_value_in;
      char_error_ff     <= char_error_in;
      run_last_ff       <= run_last_in;
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.bar_pattern    = bar_pattern_ff;
   assign rsp_bus.pattern_length = pattern_length_ff;
   assign rsp_bus.symbol_value   = symbol_value_ff;
   assign rsp_bus.char_error     = char_error_ff;
   assign rsp_bus.run_last       = run_last_ff;

   a_chk_range: assert property (@(posedge clock) disable iff (reset)
      chk_ff < CHECK_MOD)
      else $error("checksum out of range");

   a_error_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && char_error_ff |-> run_last_ff && bar_pattern_ff == 13'd0)
      else $error("error result not final or pattern not zero");

   a_stop_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !char_error_ff |->
         ((pattern_length_ff == STOP_LENGTH) == (symbol_value_ff == SYM_STOP)))
      else $error("pattern length does not match symbol");

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// testbench: self-checking bench for code128b_symbol_encoder_unit.
// Depends on c128_pkg, c128_req_if, c128_rsp_if and the encoder RTL; drives
// characters, predicts every symbol with its own encoder model, checks results.

module testbench;
   import c128_pkg::*;

   // Watchdog: cycles in a row with no transaction on either channel. The longest
   // quiet stretch of a correct run is the receiver hold-off plus a few idle draws.
   localparam int STALL_LIMIT  = 2000;
   // Receiver hold-off, long enough to fill the front stages and the queue.
   localparam int HOLD_CYCLES  = 60;
   // Extra cycles after the last expected symbol.
   localparam int TAIL_CYCLES  = 12;
   // Characters to send in total, directed part included.
   localparam int CHAR_TARGET  = 180;
   localparam int IDLE_PERCENT = 38;

   // Module patterns of symbol values 0..105, first module at the MSB.
   localparam logic [10:0] BAR_TABLE [0:105] = '{
      11'b11011001100, 11'b11001101100, 11'b11001100110, 11'b10010011000,
      11'b10010001100, 11'b10001001100, 11'b10011001000, 11'b10011000100,
      11'b10001100100, 11'b11001001000, 11'b11001000100, 11'b11000100100,
      11'b10110011100, 11'b10011011100, 11'b10011001110, 11'b10111001100,
      11'b10011101100, 11'b10011100110, 11'b11001110010, 11'b11001011100,
      11'b11001001110, 11'b11011100100, 11'b11001110100, 11'b11101101110,
      11'b11101001100, 11'b11100101100, 11'b11100100110, 11'b11101100100,
      11'b11100110100, 11'b11100110010, 11'b11011011000, 11'b11011000110,
      11'b11000110110, 11'b10100011000, 11'b10001011000, 11'b10001000110,
      11'b10110001000, 11'b10001101000, 11'b10001100010, 11'b11010001000,
      11'b11000101000, 11'b11000100010, 11'b10110111000, 11'b10110001110,
      11'b10001101110, 11'b10111011000, 11'b10111000110, 11'b10001110110,
      11'b11101110110, 11'b11010001110, 11'b11000101110, 11'b11011101000,
      11'b11011100010, 11'b11011101110, 11'b11101011000, 11'b11101000110,
      11'b11100010110, 11'b11101101000, 11'b11101100010, 11'b11100011010,
      11'b11101111010, 11'b11001000010, 11'b11110001010, 11'b10100110000,
      11'b10100001100, 11'b10010110000, 11'b10010000110, 11'b10000101100,
      11'b10000100110, 11'b10110010000, 11'b10110000100, 11'b10011010000,
      11'b10011000010, 11'b10000110100, 11'b10000110010, 11'b11000010010,
      11'b11001010000, 11'b11110111010, 11'b11000010100, 11'b10001111010,
      11'b10100111100, 11'b10010111100, 11'b10010011110, 11'b10111100100,
      11'b10011110100, 11'b10011110010, 11'b11110100100, 11'b11110010100,
      11'b11110010010, 11'b11011011110, 11'b11011110110, 11'b11110110110,
      11'b10101111000, 11'b10100011110, 11'b10001011110, 11'b10111101000,
      11'b10111100010, 11'b11110101000, 11'b11110100010, 11'b10111011110,
      11'b10111101110, 11'b11101011110, 11'b11110101110, 11'b11010000100,
      11'b11010010000, 11'b11010011100
   };
   localparam logic [12:0] STOP_BARS = 13'b1100011101011;

   // One symbol as seen on the result channel.
   typedef struct packed {
      logic [12:0] bars;
      logic [3:0]  length;
      logic [6:0]  value;
      logic        err;
      logic        last;
   } symbol_word_type;

   // Encoder model plus the queue of symbols still owed by the block.
   class symbol_scoreboard;
      symbol_word_type expected_symbols[$];
      bit              in_message  = 1'b0;
      int              running_sum = 0;   // checksum mod 103
      int              weight      = 0;   // position of the next character mod 103
      int              mismatches  = 0;

      function symbol_word_type make_symbol(input int sym, input logic err,
                                            input logic last);
         symbol_word_type s;
         s.err  = err;
         s.last = last;
         if (err) begin
            s.bars   = '0;
            s.length = BASE_LENGTH;
            s.value  = '0;
         end else if (sym == int'(SYM_STOP)) begin
            s.bars   = STOP_BARS;
            s.length = STOP_LENGTH;
            s.value  = sym[6:0];
         end else begin
            s.bars   = {2'b00, BAR_TABLE[sym]};
            s.length = BASE_LENGTH;
            s.value  = sym[6:0];
         end
         return s;
      endfunction

      // Adds one symbol at the tail of the owed list.
      function void owe_symbol(input symbol_word_type s);
         expected_symbols.insert(expected_symbols.size(), s);
      endfunction

      // Accepted character: queue every symbol it causes, in order.
      function void note_char(input logic [7:0] code, input logic last_char);
         int code_value;
         if (code < CHAR_LOW || code > CHAR_HIGH) begin
            // abort: lone error symbol, message_end does not matter
            owe_symbol(make_symbol(0, 1'b1, 1'b1));
            in_message  = 1'b0;
            running_sum = 0;
            weight      = 0;
            return;
         end
         if (!in_message) begin
            owe_symbol(make_symbol(int'(SYM_START_B), 1'b0, 1'b0));
            running_sum = int'(SYM_START_B) % int'(CHECK_MOD);
            weight      = 1;
            in_message  = 1'b1;
         end
         code_value  = int'(code) - int'(CHAR_LOW);
         running_sum = (running_sum + code_value * weight) % int'(CHECK_MOD);
         weight      = (weight + 1) % int'(CHECK_MOD);
         owe_symbol(make_symbol(code_value, 1'b0, !last_char));
         if (last_char) begin
            owe_symbol(make_symbol(running_sum, 1'b0, 1'b0));
            owe_symbol(make_symbol(int'(SYM_STOP), 1'b0, 1'b1));
            in_message  = 1'b0;
            running_sum = 0;
            weight      = 0;
         end
      endfunction

      function void check_symbol(input symbol_word_type got);
         symbol_word_type want;
         if (expected_symbols.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected symbol, expected none, got value %0d pattern %b",
                     $time, got.value, got.bars);
            return;
         end
         want = expected_symbols.pop_front();
         if (want != got) begin
            mismatches++;
            if (want.bars != got.bars)
               $display("%0t: bar_pattern expected %b got %b", $time, want.bars, got.bars);
            if (want.length != got.length)
               $display("%0t: pattern_length expected %0d got %0d", $time,
                        want.length, got.length);
            if (want.value != got.value)
               $display("%0t: symbol_value expected %0d got %0d", $time,
                        want.value, got.value);
            if (want.err != got.err)
               $display("%0t: char_error expected %0d got %0d", $time, want.err, got.err);
            if (want.last != got.last)
               $display("%0t: run_last expected %0d got %0d", $time, want.last, got.last);
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   c128_req_if req_if ();
   c128_rsp_if rsp_if ();

   symbol_scoreboard scoreboard = new();

   // Idle controls for the two drivers; hold_off_req asks the receiver
   // for one long stall while the sender keeps pushing characters.
   bit tx_idle_on   = 1'b1;
   bit rx_idle_on   = 1'b1;
   bit hold_off_req = 1'b0;
   int chars_sent   = 0;

   code128b_symbol_encoder_unit u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Any byte outside the printable range.
   function automatic logic [7:0] bad_byte();
      if ($urandom_range(0, 1) == 0)
         return 8'($urandom_range(0, 31));
      return 8'($urandom_range(127, 255));
   endfunction

   // One character transaction: optional idle cycles, then hold valid until the
   // block takes it. Everything changes at the falling edge.
   task automatic send_char(input logic [7:0] code, input logic last_char);
      while (tx_idle_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.char_code   <= code;
      req_if.message_end <= last_char;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      chars_sent++;
      @(negedge clock);
   endtask

   // Well-formed message of random printable characters. With may_abort a
   // bad byte may land inside it; whatever follows then forms a new message.
   task automatic send_message(input int length, input bit may_abort);
      int bad_at;
      int i;
      bad_at = -1;
      if (may_abort && $urandom_range(0, 99) < 15)
         bad_at = $urandom_range(0, length - 1);
      for (i = 0; i < length; i++) begin
         if (i == bad_at)
            send_char(bad_byte(), 1'($urandom_range(0, 1)));
         else
            send_char(8'($urandom_range(32, 126)), i == length - 1);
      end
   endtask

   // Receiver: random ready, one long hold-off on request.
   initial begin : rsp_driver
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_off_req = 1'b0;
         end else begin
            rsp_if.ready <= !rx_idle_on || ($urandom_range(0, 99) >= IDLE_PERCENT);
         end
      end
   end

   // Both channels are observed at the rising edge; a character accepted in a
   // cycle cannot produce a symbol in the same cycle, so order here is safe.
   initial begin : bus_monitor
      symbol_word_type got;
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (req_if.valid && req_if.ready)
               scoreboard.note_char(req_if.char_code, req_if.message_end);
            if (rsp_if.valid && rsp_if.ready) begin
               got.bars   = rsp_if.bar_pattern;
               got.length = rsp_if.pattern_length;
               got.value  = rsp_if.symbol_value;
               got.err    = rsp_if.char_error;
               got.last   = rsp_if.run_last;
               scoreboard.check_symbol(got);
            end
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("tb: failure");
      $finish;
   end

   initial begin : stimulus
      int length;
      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.char_code   = '0;
      req_if.message_end = 1'b0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: one-character messages at both ends of the printable range,
      // bad bytes on both sides of it and at 0 / 255, with and without the
      // end flag, a bad byte as first character and in the middle of a message.
      send_char(8'd32, 1'b1);
      send_char(8'd126, 1'b1);
      send_char(8'd31, 1'b0);
      send_char(8'd127, 1'b1);
      send_char(8'd0, 1'b0);
      send_char(8'd255, 1'b1);
      send_char(8'd65, 1'b0);
      send_char(8'd66, 1'b0);
      send_char(8'd200, 1'b1);     // abort mid-message, end flag ignored
      send_char(8'd67, 1'b1);      // opens a fresh message
      send_char(8'd97, 1'b0);
      send_char(8'd122, 1'b0);
      send_char(8'd48, 1'b0);
      send_char(8'd33, 1'b0);
      send_char(8'd125, 1'b1);
      send_char(8'd128, 1'b0);
      send_char(8'd126, 1'b0);
      send_char(8'd32, 1'b1);

      // Back-to-back with no idling, receiver stalled long enough that the
      // block backs up and drops req ready.
      tx_idle_on   = 1'b0;
      rx_idle_on   = 1'b0;
      hold_off_req = 1'b1;
      while (chars_sent < 60)
         send_message($urandom_range(1, 8), 1'b1);

      // Long message: position weight wraps past 103.
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
      send_message(110, 1'b0);

      // Mostly short messages, some bad bytes between them.
      while (chars_sent < CHAR_TARGET) begin
         if ($urandom_range(0, 99) < 6) begin
            send_char(bad_byte(), 1'($urandom_range(0, 1)));
         end else begin
            length = ($urandom_range(0, 99) < 70) ? $urandom_range(1, 4)
                                                 : $urandom_range(5, 16);
            send_message(length, 1'b1);
         end
      end
      req_if.valid <= 1'b0;

      // Drain, then wait TAIL_CYCLES more to catch stray symbols.
      while (scoreboard.expected_symbols.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (scoreboard.mismatches == 0 && scoreboard.expected_symbols.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
